### sv/cat_tsf_pkg.sv
// Shared types and constants for the cat-style text stream filter.
// No dependencies; imported by every module of the block.
package cat_tsf_pkg;

    localparam int NUMBER_DIGITS_DEF = 6;
    localparam int COUNT_DIGITS_MAX  = 6;
    localparam int CFG_INDEX_W       = 3;
    localparam int CFG_DATA_W        = 2;
    localparam int CHAR_MAX          = 4;

    localparam logic [7:0] CH_NL      = 8'h0A;
    localparam logic [7:0] CH_TAB     = 8'h09;
    localparam logic [7:0] CH_HIGH_NL = 8'h8A;
    localparam logic [7:0] CH_DEL     = 8'h7F;
    localparam logic [7:0] CH_CTRL_HI = 8'h1F;
    localparam logic [7:0] CH_META_LO = 8'h80;
    localparam logic [7:0] CH_META_HI = 8'h9F;
    localparam logic [7:0] CH_CARET   = 8'h5E;
    localparam logic [7:0] CH_QUEST   = 8'h3F;
    localparam logic [7:0] CH_M       = 8'h4D;
    localparam logic [7:0] CH_DASH    = 8'h2D;
    localparam logic [7:0] CH_DOLLAR  = 8'h24;
    localparam logic [7:0] CH_I       = 8'h49;
    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CTRL_SHIFT = 8'h40;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_NUMBER_MODE      = 3'd0,
        REG_SQUEEZE_BLANK    = 3'd1,
        REG_SHOW_NONPRINTING = 3'd2,
        REG_SHOW_ENDS        = 3'd3,
        REG_SHOW_TABS        = 3'd4
    } cfg_reg_t;

    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_ALL      = 2'd1;
    localparam logic [1:0] MODE_NONBLANK = 2'd2;

    typedef struct packed {
        logic [1:0] number_mode;
        logic       squeeze_blank;
        logic       show_nonprinting;
        logic       show_ends;
        logic       show_tabs;
    } cfg_t;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       file_start;
    } in_word_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [CHAR_MAX-1:0][7:0] bytes;
        logic [2:0]               len;
    } char_part_t;

endpackage

### sv/cat_tsf_decide.sv
// Per-word decision stage: line state, BCD line counter and character rendering.
// Depends on cat_tsf_pkg.
module cat_tsf_decide
    import cat_tsf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
    parameter int COUNT_DIGITS  = (NUMBER_DIGITS < COUNT_DIGITS_MAX) ? NUMBER_DIGITS
                                                                     : COUNT_DIGITS_MAX
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         accept,
    input  in_word_t                     in_word,
    input  cfg_t                         cfg,
    output logic                         load,
    output logic                         num,
    output logic [COUNT_DIGITS-1:0][3:0] digits,
    output logic [COUNT_DIGITS-1:0]      nonblank,
    output char_part_t                   char_part
);

    logic [7:0]                   prev_byte_reg;
    logic                         blank_seen_reg;
    logic [COUNT_DIGITS-1:0][3:0] count_reg;
    logic [COUNT_DIGITS-1:0][3:0] count_next;
    logic [COUNT_DIGITS-1:0][3:0] count_cur;
    logic [7:0]                   prev_byte;
    logic [7:0]                   c;
    logic                         blank_seen;
    logic                         squeezed;
    logic                         starts;
    logic                         count_is_one;
    logic                         count_full;
    logic                         carry;
    logic                         any_high;

    assign c          = in_word.in_byte;
    assign prev_byte  = in_word.file_start ? 8'h00 : prev_byte_reg;
    assign blank_seen = in_word.file_start ? 1'b0  : blank_seen_reg;

    always_comb begin
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            count_cur[i] = in_word.file_start ? ((i == 0) ? 4'd1 : 4'd0) : count_reg[i];
        end
    end

    always_comb begin
        count_is_one = 1'b1;
        count_full   = 1'b1;
        carry        = 1'b1;
        any_high     = 1'b0;
        for (int i = 0; i < COUNT_DIGITS; i++) begin
            count_is_one = count_is_one && (count_cur[i] == ((i == 0) ? 4'd1 : 4'd0));
            count_full   = count_full && (count_cur[i] == 4'd9);
            if (carry && count_cur[i] == 4'd9) begin
                count_next[i] = 4'd0;
            end else begin
                count_next[i] = carry ? count_cur[i] + 4'd1 : count_cur[i];
                carry         = 1'b0;
            end
        end
        for (int i = COUNT_DIGITS - 1; i >= 0; i--) begin
            any_high    = any_high || (count_cur[i] != 4'd0);
            nonblank[i] = any_high || (i == 0);
        end
    end

    assign squeezed = cfg.squeeze_blank && prev_byte == CH_NL && c == CH_NL && blank_seen;
    assign starts   = count_is_one || prev_byte == CH_NL
                   || (cfg.show_nonprinting && c != CH_NL && c != CH_HIGH_NL
                       && prev_byte == CH_HIGH_NL);

    always_comb begin
        case (cfg.number_mode)
            MODE_ALL:      num = starts;
            MODE_NONBLANK: num = starts && c != CH_NL;
            default:       num = 1'b0;
        endcase
    end

    assign load   = accept && !squeezed;
    assign digits = count_cur;

    always_comb begin
        char_part.bytes = '0;
        char_part.len   = 3'd1;
        char_part.bytes[0] = c;
        if (cfg.show_nonprinting && c != CH_NL && c != CH_TAB) begin
            if (c >= CH_META_LO && c <= CH_META_HI) begin
                char_part.bytes[0] = CH_M;
                char_part.bytes[1] = CH_DASH;
                char_part.bytes[2] = CH_CARET;
                char_part.bytes[3] = c - CTRL_SHIFT;
                char_part.len      = 3'd4;
            end else if (c <= CH_CTRL_HI) begin
                char_part.bytes[0] = CH_CARET;
                char_part.bytes[1] = c + CTRL_SHIFT;
                char_part.len      = 3'd2;
            end else if (c == CH_DEL) begin
                char_part.bytes[0] = CH_CARET;
                char_part.bytes[1] = CH_QUEST;
                char_part.len      = 3'd2;
            end
        end else if (cfg.show_ends && c == CH_NL) begin
            char_part.bytes[0] = CH_DOLLAR;
            char_part.bytes[1] = CH_NL;
            char_part.len      = 3'd2;
        end else if (cfg.show_tabs && c == CH_TAB) begin
            char_part.bytes[0] = CH_CARET;
            char_part.bytes[1] = CH_I;
            char_part.len      = 3'd2;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prev_byte_reg  <= 8'h00;
            blank_seen_reg <= 1'b0;
            for (int i = 0; i < COUNT_DIGITS; i++) begin
                count_reg[i] <= (i == 0) ? 4'd1 : 4'd0;
            end
        end else if (load) begin
            prev_byte_reg  <= c;
            blank_seen_reg <= (prev_byte == CH_NL) && (c == CH_NL);
            count_reg      <= (num && !count_full) ? count_next : count_cur;
        end
    end

    generate
        for (genvar g = 0; g < COUNT_DIGITS; g++) begin : g_digit_chk
            a_bcd_digit: assert property (@(posedge aclk) disable iff (!aresetn)
                count_reg[g] <= 4'd9)
                else $error("line counter digit left decimal range");
        end
    endgenerate

    a_squeeze_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && squeezed) |=> $stable(prev_byte_reg) && $stable(blank_seen_reg))
        else $error("dropped newline changed line state");

endmodule

### sv/cat_tsf_serial.sv
// Descriptor register and byte serializer that expands one word into output bytes.
// Depends on cat_tsf_pkg.
module cat_tsf_serial
    import cat_tsf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF,
    parameter int COUNT_DIGITS  = (NUMBER_DIGITS < COUNT_DIGITS_MAX) ? NUMBER_DIGITS
                                                                     : COUNT_DIGITS_MAX
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         load,
    input  logic                         num,
    input  logic [COUNT_DIGITS-1:0][3:0] digits,
    input  logic [COUNT_DIGITS-1:0]      nonblank,
    input  char_part_t                   char_part,
    output logic                         free,
    output logic                         m_valid,
    input  logic                         m_ready,
    output out_word_t                    m_data
);

    localparam int PW = $clog2(NUMBER_DIGITS + CHAR_MAX + 2);

    logic                         valid_reg;
    logic                         num_reg;
    logic [COUNT_DIGITS-1:0][3:0] digits_reg;
    logic [COUNT_DIGITS-1:0]      nonblank_reg;
    char_part_t                   char_reg;
    logic [PW-1:0]                pos_reg;
    logic [PW-1:0]                num_len;
    logic [PW-1:0]                total;
    logic [PW-1:0]                col_idx;
    logic [PW-1:0]                char_pos;
    logic                         last;
    logic                         pop;
    logic [7:0]                   out_byte;

    assign num_len  = num_reg ? PW'(NUMBER_DIGITS + 1) : '0;
    assign total    = num_len + PW'(char_reg.len);
    assign last     = (pos_reg == total - PW'(1));
    assign pop      = valid_reg && m_ready;
    assign free     = !valid_reg || (pop && last);
    assign col_idx  = PW'(NUMBER_DIGITS - 1) - pos_reg;
    assign char_pos = pos_reg - num_len;

    always_comb begin
        out_byte = char_reg.bytes[char_pos[1:0]];
        if (num_reg && pos_reg < PW'(NUMBER_DIGITS)) begin
            out_byte = CH_SPACE;
            for (int i = 0; i < COUNT_DIGITS; i++) begin
                if (col_idx == PW'(i) && nonblank_reg[i]) begin
                    out_byte = CH_ZERO | {4'h0, digits_reg[i]};
                end
            end
        end else if (num_reg && pos_reg == PW'(NUMBER_DIGITS)) begin
            out_byte = CH_TAB;
        end
    end

    assign m_valid            = valid_reg;
    assign m_data.out_byte    = out_byte;
    assign m_data.last_of_run = last;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else if (load) begin
            valid_reg <= 1'b1;
            pos_reg   <= '0;
        end else if (pop) begin
            valid_reg <= !last;
            pos_reg   <= last ? '0 : pos_reg + PW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            num_reg      <= num;
            digits_reg   <= digits;
            nonblank_reg <= nonblank;
            char_reg     <= char_part;
        end
    end

    a_pos_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> pos_reg < total)
        else $error("serializer position ran past the end of the word");

    a_load_when_free: assert property (@(posedge aclk) disable iff (!aresetn)
        load |-> free)
        else $error("descriptor loaded while previous word still pending");

    a_run_continues: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && !last) |=> valid_reg && pos_reg == $past(pos_reg) + PW'(1))
        else $error("serializer lost a byte inside a run");

    a_char_len: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg |-> (char_reg.len >= 3'd1 && char_reg.len <= 3'd4))
        else $error("rendered character length out of range");

endmodule

### sv/cat_text_stream_filter_top.sv
// Latency: a loaded word's first output byte is valid the cycle after the word is accepted.
// Throughput: a word holds the serializer until its final byte is taken, and a squeezed
// newline never enters it; single-byte words stream at one per cycle while m_ready is high.
// The next word is accepted in the cycle the previous word's final byte is taken.
// Reset (aresetn low, synchronous) clears the configuration and line-state registers to
// zero, sets the line counter to one and empties the serializer.
module cat_text_stream_filter_top
    import cat_tsf_pkg::*;
#(
    parameter int NUMBER_DIGITS = NUMBER_DIGITS_DEF
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_word_t               s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_word_t              m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int COUNT_DIGITS = (NUMBER_DIGITS < COUNT_DIGITS_MAX) ? NUMBER_DIGITS
                                                                     : COUNT_DIGITS_MAX;

    cfg_t                         cfg_reg;
    logic                         accept;
    logic                         load;
    logic                         num;
    logic [COUNT_DIGITS-1:0][3:0] digits;
    logic [COUNT_DIGITS-1:0]      nonblank;
    char_part_t                   char_part;
    logic                         free;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_NUMBER_MODE:      cfg_reg.number_mode      <= cfg_wdata;
                REG_SQUEEZE_BLANK:    cfg_reg.squeeze_blank    <= cfg_wdata[0];
                REG_SHOW_NONPRINTING: cfg_reg.show_nonprinting <= cfg_wdata[0];
                REG_SHOW_ENDS:        cfg_reg.show_ends        <= cfg_wdata[0];
                REG_SHOW_TABS:        cfg_reg.show_tabs        <= cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    assign s_ready = free;
    assign accept  = s_valid && s_ready;

    cat_tsf_decide #(
        .NUMBER_DIGITS (NUMBER_DIGITS),
        .COUNT_DIGITS  (COUNT_DIGITS)
    ) u_decide (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .accept    (accept),
        .in_word   (s_data),
        .cfg       (cfg_reg),
        .load      (load),
        .num       (num),
        .digits    (digits),
        .nonblank  (nonblank),
        .char_part (char_part)
    );

    cat_tsf_serial #(
        .NUMBER_DIGITS (NUMBER_DIGITS),
        .COUNT_DIGITS  (COUNT_DIGITS)
    ) u_serial (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .num       (num),
        .digits    (digits),
        .nonblank  (nonblank),
        .char_part (char_part),
        .free      (free),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule
